FILE: rtl/core/lruac_pkg.sv
// Shared types and codes for the counter-based LRU replacement unit.
// No dependencies; used by the top-level replacement unit.
package lruac_pkg;

  localparam logic OP_ACCESS = 1'b0;
  localparam logic OP_VICTIM = 1'b1;

  localparam int SET_FIELD_W = 6;
  localparam int WAY_FIELD_W = 3;

  typedef struct packed {
    logic                   op;
    logic [SET_FIELD_W-1:0] set_index;
    logic [WAY_FIELD_W-1:0] way_index;
  } lruac_in_t;

  typedef struct packed {
    logic [SET_FIELD_W-1:0] victim_set;
    logic [WAY_FIELD_W-1:0] victim_way;
  } lruac_out_t;

endpackage

FILE: rtl/core/lruac_row_mem.sv
// Age counter store: one row per set, all ways of the set side by side.
// Synchronous, one write port and one read port, registered read data.
module lruac_row_mem #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6,
  parameter int DATA_W = 128
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/lruac_max_scan.sv
// Sequential search for the oldest way of one row, one way per cycle.
// Lowest way wins on equal ages. Depends on nothing but its ports.
module lruac_max_scan #(
  parameter int NUM_WAYS = 8,
  parameter int AGE_BITS = 16,
  parameter int WAY_W    = 3
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [NUM_WAYS*AGE_BITS-1:0] row_i,
  output logic                         done_o,
  output logic [WAY_W-1:0]             way_o
);

  localparam logic [WAY_W-1:0] LastWay = WAY_W'(NUM_WAYS - 1);

  logic                run_q;
  logic                done_q;
  logic [WAY_W-1:0]    idx_q;
  logic [WAY_W-1:0]    best_way_q;
  logic [AGE_BITS-1:0] best_age_q;
  logic [AGE_BITS-1:0] cur_age;
  logic                older;

  assign cur_age = row_i[idx_q*AGE_BITS +: AGE_BITS];
  assign older   = cur_age > best_age_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        idx_q <= WAY_W'(1);
      end else if (run_q) begin
        idx_q <= idx_q + 1'b1;
        if (idx_q == LastWay) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      best_age_q <= row_i[AGE_BITS-1:0];
      best_way_q <= '0;
    end else if (run_q && older) begin
      best_age_q <= cur_age;
      best_way_q <= idx_q;
    end
  end

  assign done_o = done_q;
  assign way_o  = best_way_q;

endmodule

FILE: rtl/core/lru_age_counter_replacement_unit.sv
// Counter-based LRU replacement unit: top level, control and row update.
// Uses lruac_pkg, lruac_row_mem and lruac_max_scan.
//
//   channel   handshake          payload                 direction
//   item      start / busy       item_i   (lruac_in_t)   in
//   result    valid_o (strobe)   result_o (lruac_out_t)  out
//
// Access: row read, then increment and write back of the whole row.
// Victim: row read, one way per cycle in the scan unit, then the way is handed
// over to result_o together with the valid_o strobe.
// Victim for a set at or beyond NUM_SETS: way 0 as result in the next cycle, no read.
// After reset busy stays high while the store is cleared row by row.
// Results appear on valid_o for one cycle; the receiver cannot stall them.
module lru_age_counter_replacement_unit #(
  parameter int NUM_SETS = 64,
  parameter int NUM_WAYS = 8,
  parameter int AGE_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  input  lruac_pkg::lruac_in_t item_i,
  output logic                 busy,
  output logic                 valid_o,
  output lruac_pkg::lruac_out_t result_o
);

  localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int WAY_W = $clog2(NUM_WAYS);
  localparam int ROW_W = NUM_WAYS * AGE_BITS;
  localparam logic [SET_W-1:0] LastSet = SET_W'(NUM_SETS - 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCAN
  } state_e;

  state_e                state_q;
  logic [SET_W-1:0]      clr_q;
  logic                  op_q;
  logic [SET_W-1:0]      addr_q;
  logic [WAY_W-1:0]      way_q;
  logic [lruac_pkg::SET_FIELD_W-1:0] set_field_q;
  logic                  valid_q;
  lruac_pkg::lruac_out_t result_q;

  logic             accept;
  logic             set_ok;
  logic             way_ok;
  logic             mem_we;
  logic [SET_W-1:0] mem_waddr;
  logic [ROW_W-1:0] mem_wdata;
  logic             mem_re;
  logic [ROW_W-1:0] row;
  logic [ROW_W-1:0] row_upd;
  logic             scan_start;
  logic             scan_done;
  logic [WAY_W-1:0] scan_way;

  assign accept = start && (state_q == ST_IDLE);
  assign set_ok = 32'(item_i.set_index) < NUM_SETS;
  assign way_ok = 32'(item_i.way_index) < NUM_WAYS;
  assign mem_re = accept && set_ok && ((item_i.op == lruac_pkg::OP_VICTIM) || way_ok);

  // Age every way by one, saturating, then clear the touched way.
  always_comb begin
    logic [AGE_BITS-1:0] age;
    for (int w = 0; w < NUM_WAYS; w++) begin
      age = row[w*AGE_BITS +: AGE_BITS];
      if (WAY_W'(w) == way_q) begin
        row_upd[w*AGE_BITS +: AGE_BITS] = '0;
      end else if (&age) begin
        row_upd[w*AGE_BITS +: AGE_BITS] = age;
      end else begin
        row_upd[w*AGE_BITS +: AGE_BITS] = age + 1'b1;
      end
    end
  end

  assign mem_we     = (state_q == ST_CLEAR) ||
                      ((state_q == ST_READ) && (op_q == lruac_pkg::OP_ACCESS));
  assign mem_waddr  = (state_q == ST_CLEAR) ? clr_q : addr_q;
  assign mem_wdata  = (state_q == ST_CLEAR) ? '0 : row_upd;
  assign scan_start = (state_q == ST_READ) && (op_q == lruac_pkg::OP_VICTIM);

  lruac_row_mem #(
    .DEPTH  (NUM_SETS),
    .ADDR_W (SET_W),
    .DATA_W (ROW_W)
  ) u_row_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (SET_W'(item_i.set_index)),
    .rdata_o (row)
  );

  lruac_max_scan #(
    .NUM_WAYS (NUM_WAYS),
    .AGE_BITS (AGE_BITS),
    .WAY_W    (WAY_W)
  ) u_max_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (scan_start),
    .row_i   (row),
    .done_o  (scan_done),
    .way_o   (scan_way)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == LastSet) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (mem_re) begin
            state_q <= ST_READ;
          end else if (accept && (item_i.op == lruac_pkg::OP_VICTIM)) begin
            // set beyond the store: answer way 0 right away
            valid_q <= 1'b1;
          end
        end
        ST_READ: begin
          state_q <= (op_q == lruac_pkg::OP_VICTIM) ? ST_SCAN : ST_IDLE;
        end
        ST_SCAN: begin
          if (scan_done) begin
            valid_q <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Payload registers: capture the transaction and the result.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q        <= item_i.op;
      addr_q      <= SET_W'(item_i.set_index);
      way_q       <= WAY_W'(item_i.way_index);
      set_field_q <= item_i.set_index;
      if (!mem_re) begin
        result_q.victim_set <= item_i.set_index;
        result_q.victim_way <= '0;
      end
    end else if ((state_q == ST_SCAN) && scan_done) begin
      result_q.victim_set <= set_field_q;
      result_q.victim_way <= lruac_pkg::WAY_FIELD_W'(scan_way);
    end
  end

  assign busy     = (state_q != ST_IDLE);
  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule
